FILE: rtl/gconv_pkg.sv
// ----------------------------------------------------------------------------
// gconv_pkg
// Shared types and constants for the 3x3 grayscale convolution block.
// ----------------------------------------------------------------------------
package gconv_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 1024;
  localparam int KSIZE          = 3;
  localparam int KTAPS          = KSIZE * KSIZE;
  localparam int COEF_FRAC_BITS = 10;
  localparam int COEF_W         = 18;
  localparam int PIX_W          = 8;
  localparam int DIM_W          = 11;
  localparam int CIDX_W         = 4;
  localparam int PROD_W         = PIX_W + 1 + COEF_W;
  localparam int SUM_W          = PROD_W + 4;
  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  typedef enum logic [1:0] {
    FUNC_COEF  = 2'd0,
    FUNC_PIXEL = 2'd1,
    FUNC_DRAIN = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  // per-pixel control carried down the pipeline
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [KTAPS-1:0] mask;
  } tap_ctl_t;

endpackage

FILE: rtl/grayscale_2d_convolution.sv
// ----------------------------------------------------------------------------
// grayscale_2d_convolution
// 3x3 zero-padded convolution of a raster pixel stream, two-row line buffer.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tuser=func, tdata=index/coef/pixel
// m_axis    out  tvalid/tready          tdata=out_pixel, tlast=out_last
// cfg       in   cfg_we_i               cfg_idx_i, cfg_data_i
//
// One transaction per clock unless m_axis stalls; a result passes the line
// RAM read, window, multiply, and sum and saturate registers.
// The line RAM read-modify-write sets the pace: one column per cycle, with
// forwarding when the same column is written and read in one cycle.
// The whole pipeline stalls only while a result waits on m_axis_tready_i.
// Reset clears counters, kernel and valid bits; the line RAM is not cleared.
// ----------------------------------------------------------------------------
module grayscale_2d_convolution #(
  parameter int MAX_WIDTH  = gconv_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = gconv_pkg::MAX_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // coef_index[3:0], coef_value[21:4], pixel_value[29:22]
  input  logic [1:0]  s_axis_tuser_i,  // func[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // out_pixel[7:0]
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int PW = gconv_pkg::PIX_W;
  localparam int KS = gconv_pkg::KSIZE;
  localparam int KT = gconv_pkg::KTAPS;

  // configuration
  logic [gconv_pkg::DIM_W-1:0] width_q, height_q;
  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = RW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(height_q);
    end
  end

  // input decode
  gconv_pkg::func_e func;
  logic [gconv_pkg::CIDX_W-1:0]  in_cidx;
  logic signed [gconv_pkg::COEF_W-1:0] in_cval;
  logic [PW-1:0] in_pix;
  logic en, accept, frame_idle, is_pix, is_coef, emit, last, col_end;
  logic [PW-1:0] p_in;
  logic [KS-1:0] row_ok, col_ok;
  gconv_pkg::tap_ctl_t ctl_d;

  logic [CW-1:0] in_col_q;
  logic [RW-1:0] in_row_q, orow_q;
  logic [CW-1:0] ocol_q;

  assign func    = gconv_pkg::func_e'(s_axis_tuser_i);
  assign in_cidx = s_axis_tdata_i[3:0];
  assign in_cval = $signed(s_axis_tdata_i[21:4]);
  assign in_pix  = s_axis_tdata_i[29:22];

  logic o_valid_q;
  assign en              = !o_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i && en;

  always_comb begin
    frame_idle = (in_col_q == '0) && (in_row_q == '0) && (orow_q == '0) && (ocol_q == '0);
    is_pix  = (func == gconv_pkg::FUNC_PIXEL) || ((func == gconv_pkg::FUNC_DRAIN) && !frame_idle);
    is_coef = (func == gconv_pkg::FUNC_COEF) && (in_cidx < gconv_pkg::CIDX_W'(KT));
    p_in    = (func == gconv_pkg::FUNC_PIXEL) ? in_pix : '0;
    // output lags the input by one row plus one pixel
    emit    = (in_row_q > RW'(1)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
    col_end = (WW'(in_col_q) + WW'(1)) == w_eff;
    last    = emit && (orow_q == h_eff - RW'(1)) && (WW'(ocol_q) + WW'(1) == w_eff);
    row_ok  = {(orow_q + RW'(1)) < h_eff, 1'b1, orow_q != '0};
    col_ok  = {(WW'(ocol_q) + WW'(1)) < w_eff, 1'b1, ocol_q != '0};
    for (int m = 0; m < KS; m++) begin
      for (int n = 0; n < KS; n++) begin
        ctl_d.mask[m*KS+n] = row_ok[m] & col_ok[n];
      end
    end
    ctl_d.emit = emit;
    ctl_d.last = last;
  end

  // frame counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gconv_pkg::DIM_RESET;
      height_q <= gconv_pkg::DIM_RESET;
      in_col_q <= '0;
      in_row_q <= '0;
      orow_q   <= '0;
      ocol_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (gconv_pkg::cfg_idx_e'(cfg_idx_i))
        gconv_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
        gconv_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
      in_col_q <= '0;
      in_row_q <= '0;
      orow_q   <= '0;
      ocol_q   <= '0;
    end else if (accept && is_pix) begin
      if (last) begin
        in_col_q <= '0;
        in_row_q <= '0;
        orow_q   <= '0;
        ocol_q   <= '0;
      end else begin
        if (col_end) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + RW'(1);
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
        if (emit) begin
          if (WW'(ocol_q) + WW'(1) == w_eff) begin
            ocol_q <= '0;
            orow_q <= orow_q + RW'(1);
          end else begin
            ocol_q <= ocol_q + CW'(1);
          end
        end
      end
    end
  end

  // stage 1: line RAM read-modify-write
  logic s1_pix_q, s1_coef_q, fwd_q;
  logic [PW-1:0] s1_p_q;
  logic [CW-1:0] s1_addr_q;
  logic [gconv_pkg::CIDX_W-1:0] s1_cidx_q;
  logic signed [gconv_pkg::COEF_W-1:0] s1_cval_q;
  gconv_pkg::tap_ctl_t s1_ctl_q;
  logic [2*PW-1:0] ram_rdata, line_rd, line_wdata, fwd_data_q;
  logic ram_we;

  // word layout: [PW-1:0] older row, [2*PW-1:PW] previous row
  assign line_rd    = fwd_q ? fwd_data_q : ram_rdata;
  assign line_wdata = {s1_p_q, line_rd[2*PW-1:PW]};
  assign ram_we     = en && s1_pix_q;

  gconv_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (line_wdata),
    .re_i    (accept),
    .raddr_i (in_col_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_pix_q  <= 1'b0;
      s1_coef_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else if (en) begin
      s1_pix_q  <= accept && is_pix;
      s1_coef_q <= accept && is_coef;
      fwd_q     <= s1_pix_q && accept && (s1_addr_q == in_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fwd_data_q <= line_wdata;
      if (accept) begin
        s1_p_q    <= p_in;
        s1_addr_q <= in_col_q;
        s1_cidx_q <= in_cidx;
        s1_cval_q <= in_cval;
        s1_ctl_q  <= ctl_d;
      end
    end
  end

  // stage 2: window and kernel
  logic [PW-1:0] win_q [KS][KS];
  logic signed [gconv_pkg::COEF_W-1:0] coef_q [KT];
  logic s2_vld_q;
  gconv_pkg::tap_ctl_t s2_ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      for (int i = 0; i < KT; i++) begin
        coef_q[i] <= '0;
      end
    end else if (en) begin
      s2_vld_q <= s1_pix_q && s1_ctl_q.emit;
      if (s1_coef_q) begin
        coef_q[s1_cidx_q] <= s1_cval_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s1_pix_q) begin
      for (int m = 0; m < KS; m++) begin
        for (int n = 0; n < KS - 1; n++) begin
          win_q[m][n] <= win_q[m][n+1];
        end
      end
      win_q[0][KS-1] <= line_rd[PW-1:0];
      win_q[1][KS-1] <= line_rd[2*PW-1:PW];
      win_q[2][KS-1] <= s1_p_q;
      s2_ctl_q       <= s1_ctl_q;
    end
  end

  // stage 3: products, kernel flipped
  logic signed [gconv_pkg::PROD_W-1:0] prod_q [KT];
  logic s3_vld_q, s3_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s2_vld_q) begin
      s3_last_q <= s2_ctl_q.last;
      for (int m = 0; m < KS; m++) begin
        for (int n = 0; n < KS; n++) begin
          if (s2_ctl_q.mask[m*KS+n]) begin
            prod_q[m*KS+n] <= $signed({1'b0, win_q[m][n]}) *
                              coef_q[(KS-1-m)*KS + (KS-1-n)];
          end else begin
            prod_q[m*KS+n] <= '0;
          end
        end
      end
    end
  end

  // stage 4: sum, truncate, saturate
  logic signed [gconv_pkg::SUM_W-1:0] sum;
  logic signed [gconv_pkg::SUM_W-1:0] sum_int;
  logic [PW-1:0] pix_d;
  logic [PW-1:0] o_pix_q;
  logic          o_last_q;

  always_comb begin
    sum = '0;
    for (int i = 0; i < KT; i++) begin
      sum = sum + gconv_pkg::SUM_W'(prod_q[i]);
    end
    // a negative sum shifts to a negative integer, so it clips to zero
    sum_int = sum >>> gconv_pkg::COEF_FRAC_BITS;
    if (sum < 0) begin
      pix_d = '0;
    end else if (sum_int > gconv_pkg::SUM_W'(255)) begin
      pix_d = '1;
    end else begin
      pix_d = sum_int[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (en) begin
      o_valid_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s3_vld_q) begin
      o_pix_q  <= pix_d;
      o_last_q <= s3_last_q;
    end
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = o_pix_q;
  assign m_axis_tlast_o  = o_last_q;

`ifndef ASSERT_OFF
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(in_col_q) < w_eff)
    else $error("input column beyond image width");

  a_orow_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    orow_q < h_eff)
    else $error("output row beyond image height");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_pix && last && !cfg_we_i) |=> (in_col_q == '0 && in_row_q == '0))
    else $error("frame counters not cleared after last pixel");

  a_fwd_on_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && accept && (s1_addr_q == in_col_q)) |=> fwd_q)
    else $error("line write and read of one column without forwarding");
`endif

endmodule

FILE: rtl/gconv_ram.sv
// ----------------------------------------------------------------------------
// gconv_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gconv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
